FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CTPR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ctpr assertion failed");

// checked on every rising edge, also in reset
`define CTPR_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ctpr assertion failed");

`endif

FILE: hdl/ctpr_pkg.sv
package ctpr_pkg;

  localparam int PIX_W = 12;
  localparam int XY_W = 20;
  localparam int REM_W = 24;
  localparam int RAD_W = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int DIV_STEPS = 6;

  localparam logic [31:0] TURN_ZERO = 32'h0000_0000;
  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF = 32'h8000_0000;
  localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic [5:0] LABEL_BG = 6'd0;
  localparam logic [5:0] LABEL_FG = 6'd1;
  localparam logic [5:0] LABEL_CODE_BASE = 6'd3;

  localparam logic [15:0] RST_CENTER_X = 16'd14376;
  localparam logic [15:0] RST_CENTER_Y = 16'd14376;
  localparam logic [15:0] RST_DISK_RADIUS = 16'd6718;
  localparam logic [15:0] RST_RING_INNER = 16'd9069;
  localparam logic [15:0] RST_RING_OUTER = 16'd11421;
  localparam logic [15:0] RST_ANGLE_OFFSET = 16'd0;
  localparam logic [31:0] RST_CODE_WORD = 32'd0;
  localparam logic [9:0] RST_CONTROL = 10'd905;

  localparam int CTRL_STRAIGHT = 6;
  localparam int CTRL_CHESS = 7;
  localparam int CTRL_WHITE_BG = 8;
  localparam int CTRL_ZERO_BG = 9;

  typedef enum logic [3:0] {
    REG_CENTER_X = 4'd0,
    REG_CENTER_Y = 4'd1,
    REG_DISK_RADIUS = 4'd2,
    REG_RING_INNER = 4'd3,
    REG_RING_OUTER = 4'd4,
    REG_ANGLE_OFFSET = 4'd5,
    REG_CODE_WORD = 4'd6,
    REG_CONTROL = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [5:0] label;
    logic [7:0] gray;
  } pix_out_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [31:0] z;
    logic fixed;
    logic [REM_W-1:0] rem;
    logic [4:0] quo;
    logic sat;
    logic numpos;
    logic dxpos;
    logic dyneg;
    logic code;
    logic disk;
  } stage_t;

endpackage

FILE: hdl/ctpr_stage.sv
module ctpr_stage import ctpr_pkg::*; #(
  parameter int STAGE_IDX = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  stage_t       data_i,
  input  logic [16:0]  div_d_i,
  output logic         valid_o,
  output stage_t       data_o
);

  localparam int I0 = STAGE_IDX * STEPS_PER_STAGE;

  logic   valid_q;
  stage_t data_q, data_d;

  always_comb begin
    logic signed [XY_W-1:0] xs, ys;
    logic [REM_W-1:0] dsh;
    int d;
    data_d = data_i;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      xs = data_d.x >>> (I0 + j);
      ys = data_d.y >>> (I0 + j);
      if (!data_d.fixed) begin
        if (data_d.y >= 0) begin
          data_d.x = data_d.x + ys;
          data_d.y = data_d.y - xs;
          data_d.z = data_d.z + ATAN_TURNS[I0 + j];
        end else begin
          data_d.x = data_d.x - ys;
          data_d.y = data_d.y + xs;
          data_d.z = data_d.z - ATAN_TURNS[I0 + j];
        end
      end
      d = I0 + j;
      if (d < DIV_STEPS) begin
        dsh = REM_W'(div_d_i) << (5 - d);
        if (d == 0) begin
          data_d.sat = (data_d.rem >= dsh);
        end else if (!data_d.sat && data_d.rem >= dsh) begin
          data_d.rem = data_d.rem - dsh;
          data_d.quo[5 - d] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

FILE: hdl/coded_target_pixel_renderer.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid_i/in_stall_o | pix_in_t (pixel_x, pixel_y)
// out     | out | out_valid_o/out_stall_i | pix_out_t (label, gray)
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// one pixel per cycle while the output is not stalled; 3 geometry stages, 12 angle stages, output
// angle is a 24-step cordic run two steps per stage, straight column division in stages 0-2
// the whole pipeline holds while a result waits stalled in the output register
// reset clears valid bits and loads the register defaults; no clearing pass
module coded_target_pixel_renderer import ctpr_pkg::*; #(
  parameter int MAX_CODE_BITS = 32,
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pix_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pix_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

`include "assert_macros.svh"

  logic [15:0] cx_q, cy_q, dr_q, ri_q, ro_q, aoff_q;
  logic [31:0] code_q;
  logic [9:0]  ctrl_q;
  logic [31:0] dr2_q, ri2_q, ro2_q;

  logic adv;
  logic [5:0] nbits;
  logic [4:0] half;

  assign cfg_ready_o = 1'b1;
  assign adv = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign nbits = (ctrl_q[5:0] > 6'(MAX_CODE_BITS)) ? 6'(MAX_CODE_BITS) : ctrl_q[5:0];
  assign half = nbits[5:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= RST_CENTER_X;
      cy_q <= RST_CENTER_Y;
      dr_q <= RST_DISK_RADIUS;
      ri_q <= RST_RING_INNER;
      ro_q <= RST_RING_OUTER;
      aoff_q <= RST_ANGLE_OFFSET;
      code_q <= RST_CODE_WORD;
      ctrl_q <= RST_CONTROL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CENTER_X: cx_q <= cfg_data_i[15:0];
        REG_CENTER_Y: cy_q <= cfg_data_i[15:0];
        REG_DISK_RADIUS: dr_q <= cfg_data_i[15:0];
        REG_RING_INNER: ri_q <= cfg_data_i[15:0];
        REG_RING_OUTER: ro_q <= cfg_data_i[15:0];
        REG_ANGLE_OFFSET: aoff_q <= cfg_data_i[15:0];
        REG_CODE_WORD: code_q <= cfg_data_i;
        REG_CONTROL: ctrl_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    dr2_q <= dr_q * dr_q;
    ri2_q <= ri_q * ri_q;
    ro2_q <= ro_q * ro_q;
  end

  // stage 1: offsets from the center
  logic v1_q;
  logic signed [17:0] dx_q, dy_q, dx_d, dy_d;
  logic [PIX_W-1:0] px, py;

  assign px = in_data_i.pixel_x;
  assign py = in_data_i.pixel_y;
  assign dx_d = signed'({2'b00, px, 4'b0000}) - signed'({2'b00, cx_q});
  assign dy_d = signed'({2'b00, py, 4'b0000}) - signed'({2'b00, cy_q});

  // stage 2: squares, angle setup, column numerator
  logic v2_q;
  logic [31:0] dx2_q, dy2_q;
  stage_t s2_q, s2_d;

  always_comb begin
    logic signed [18:0] sum;
    logic signed [23:0] num;
    logic [16:0] ady;
    s2_d = '0;
    if (dy_q == 0) begin
      s2_d.fixed = 1'b1;
      s2_d.z = (dx_q >= 0) ? TURN_ZERO : TURN_HALF;
    end else if (dx_q == 0) begin
      s2_d.fixed = 1'b1;
      s2_d.z = (dy_q > 0) ? TURN_QUARTER : TURN_3QUARTER;
    end else if (dx_q < 0) begin
      s2_d.x = -XY_W'(dx_q);
      s2_d.y = -XY_W'(dy_q);
      s2_d.z = TURN_HALF;
    end else begin
      s2_d.x = XY_W'(dx_q);
      s2_d.y = XY_W'(dy_q);
      s2_d.z = TURN_ZERO;
    end
    sum = 19'(dx_q) + signed'({3'b000, ro_q});
    num = 24'(sum) * signed'({19'd0, half});
    s2_d.numpos = (num > 0);
    s2_d.rem = s2_d.numpos ? REM_W'(num) : '0;
    s2_d.dxpos = (dx_q > 0);
    s2_d.dyneg = (dy_q < 0);
    ady = s2_d.dyneg ? 17'(-dy_q) : 17'(dy_q);
    s2_d.code = (ady > {1'b0, ro_q});
  end

  // stage 3: radius tests
  logic v3_q;
  stage_t s3_q, s3_d;

  always_comb begin
    logic [32:0] r2;
    r2 = {1'b0, dx2_q} + {1'b0, dy2_q};
    s3_d = s2_q;
    if (!ctrl_q[CTRL_STRAIGHT]) begin
      s3_d.code = (r2 >= {1'b0, ri2_q}) && (r2 < {1'b0, ro2_q});
    end
    s3_d.disk = (r2 < {1'b0, dr2_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      dx2_q <= 32'(dx_q * dx_q);
      dy2_q <= 32'(dy_q * dy_q);
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  // angle and division stages
  logic   vc [CORDIC_STAGES+1];
  stage_t sc [CORDIC_STAGES+1];

  assign vc[0] = v3_q;
  assign sc[0] = s3_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    ctpr_stage #(
      .STAGE_IDX(g)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vc[g]),
      .data_i  (sc[g]),
      .div_d_i ({ro_q, 1'b0}),
      .valid_o (vc[g+1]),
      .data_o  (sc[g+1])
    );
  end

  // output stage
  logic     out_valid_q;
  pix_out_t out_data_q, out_data_d;

  always_comb begin
    stage_t s;
    logic [31:0] zsum;
    logic [ANGLE_BITS-1:0] a;
    logic [ANGLE_BITS+5:0] prod;
    logic [4:0] kring, kstr, k, q, col, hm1;
    logic [7:0] bg, fg;
    logic lab1;
    s = sc[CORDIC_STAGES];
    zsum = s.z + {aoff_q, 16'h0000};
    a = zsum[31 -: ANGLE_BITS];
    prod = (ANGLE_BITS+6)'(a) * (ANGLE_BITS+6)'(nbits);
    kring = prod[ANGLE_BITS +: 5];
    q = s.sat ? 5'd31 : s.quo;
    hm1 = half - 5'd1;
    if (half == 5'd0) begin
      col = 5'd0;
    end else if (ro_q == 16'd0) begin
      col = s.dxpos ? hm1 : 5'd0;
    end else if (!s.numpos) begin
      col = 5'd0;
    end else begin
      col = (q > hm1) ? hm1 : q;
    end
    kstr = col + (s.dyneg ? half : 5'd0);
    k = ctrl_q[CTRL_STRAIGHT] ? kstr : kring;
    bg = ctrl_q[CTRL_WHITE_BG] ? 8'hFF : 8'h00;
    fg = ~bg;
    lab1 = ctrl_q[CTRL_CHESS] ? zsum[30] : 1'b1;
    if (s.code) begin
      out_data_d.label = LABEL_CODE_BASE + {1'b0, k};
      out_data_d.gray = (code_q[k] != ctrl_q[CTRL_ZERO_BG]) ? bg : fg;
    end else if (s.disk) begin
      out_data_d.label = lab1 ? LABEL_FG : LABEL_BG;
      out_data_d.gray = lab1 ? fg : bg;
    end else begin
      out_data_d.label = LABEL_BG;
      out_data_d.gray = bg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vc[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  `CTPR_ASSERT(a_stall_follows_out, out_valid_o && out_stall_i |-> in_stall_o)
  `CTPR_ASSERT(a_label_range, out_valid_o |-> out_data_o.label <= 6'd34 && out_data_o.label != 6'd2)
  `CTPR_ASSERT(a_gray_levels, out_valid_o |-> out_data_o.gray == 8'h00 || out_data_o.gray == 8'hFF)
  `CTPR_ASSERT(a_out_held, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  `CTPR_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o)

endmodule

FILE: tb/coded_target_pixel_renderer_tb.sv
module coded_target_pixel_renderer_tb;
  import ctpr_pkg::*;

  class pixel_scoreboard;
    logic [15:0] cx, cy, disk_r, ring_in, ring_out, ang_off;
    logic [31:0] code;
    logic [9:0]  ctrl;
    pix_out_t    expected_q[$];
    int          errors;

    function new();
      cx = RST_CENTER_X; cy = RST_CENTER_Y; disk_r = RST_DISK_RADIUS;
      ring_in = RST_RING_INNER; ring_out = RST_RING_OUTER;
      ang_off = RST_ANGLE_OFFSET; code = RST_CODE_WORD; ctrl = RST_CONTROL;
      errors = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] d);
      case (idx)
        REG_CENTER_X:     cx = d[15:0];
        REG_CENTER_Y:     cy = d[15:0];
        REG_DISK_RADIUS:  disk_r = d[15:0];
        REG_RING_INNER:   ring_in = d[15:0];
        REG_RING_OUTER:   ring_out = d[15:0];
        REG_ANGLE_OFFSET: ang_off = d[15:0];
        REG_CODE_WORD:    code = d;
        REG_CONTROL:      ctrl = d[9:0];
        default: ;
      endcase
    endfunction

    // polar angle in q0.32 turns, 24-step cordic
    function logic [31:0] polar_turns(longint x, longint y);
      logic [31:0] z;
      longint xs, ys;
      z = TURN_ZERO;
      if (y == 0) return (x >= 0) ? TURN_ZERO : TURN_HALF;
      if (x == 0) return (y > 0) ? TURN_QUARTER : TURN_3QUARTER;
      if (x < 0) begin
        x = -x; y = -y; z = TURN_HALF;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += ATAN_TURNS[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_TURNS[i];
        end
      end
      return z;
    endfunction

    function pix_out_t render(pix_in_t p);
      pix_out_t o;
      longint dx, dy, r2, r1, ady, num, nbits, half, col, k;
      logic [31:0] z;
      logic [7:0] bg, fg;
      bit coding;
      dx = longint'({p.pixel_x, 4'b0}) - longint'(cx);
      dy = longint'({p.pixel_y, 4'b0}) - longint'(cy);
      r2 = dx * dx + dy * dy;
      r1 = longint'(ring_out);
      nbits = ctrl[5:0];
      if (nbits > 32) nbits = 32;
      bg = ctrl[CTRL_WHITE_BG] ? 8'd255 : 8'd0;
      fg = 8'd255 - bg;
      o.label = LABEL_BG;
      o.gray = bg;
      if (ctrl[CTRL_STRAIGHT]) begin
        ady = (dy < 0) ? -dy : dy;
        coding = ady > r1;
      end else begin
        coding = r2 >= longint'(ring_in) * longint'(ring_in) && r2 < r1 * r1;
      end
      if (coding) begin
        if (ctrl[CTRL_STRAIGHT]) begin
          half = nbits / 2;
          col = 0;
          if (half != 0) begin
            if (r1 == 0) begin
              col = (dx > 0) ? half - 1 : 0;
            end else begin
              num = (dx + r1) * half;
              if (num > 0) col = num / (2 * r1);
              if (col > half - 1) col = half - 1;
            end
          end
          k = col + ((dy < 0) ? half : 0);
        end else begin
          z = polar_turns(dx, dy) + {ang_off, 16'b0};
          k = (longint'(z[31:16]) * nbits) >> 16;
        end
        k &= 31;
        o.label = LABEL_CODE_BASE + 6'(k);
        o.gray = (code[k] != ctrl[CTRL_ZERO_BG]) ? bg : fg;
      end else if (r2 < longint'(disk_r) * longint'(disk_r)) begin
        o.label = LABEL_FG;
        if (ctrl[CTRL_CHESS]) begin
          z = polar_turns(dx, dy) + {ang_off, 16'b0};
          if (!z[30]) o.label = LABEL_BG;
        end
        o.gray = (o.label == LABEL_FG) ? fg : bg;
      end
      return o;
    endfunction

    function void note_input(pix_in_t p);
      expected_q.insert(expected_q.size(), render(p));
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result label=%0d gray=%0d", got.label, got.gray);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.label !== want.label) begin
        $error("label mismatch: expected %0d actual %0d", want.label, got.label);
        errors++;
      end
      if (got.gray !== want.gray) begin
        $error("gray mismatch: expected %0d actual %0d", want.gray, got.gray);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  pix_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  pix_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  pixel_scoreboard sb = new();
  bit hold_req = 0;
  longint cycles = 0;

  coded_target_pixel_renderer uut (.*);

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls, with quiet stretches and one long hold on request
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 80);
      end
      left--;
      if (mode == 0) out_stall_i = 1'b0;
      else if (out_stall_i) out_stall_i = ($urandom_range(0, 99) < (mode == 1 ? 40 : 90));
      else out_stall_i = (pick_gap() != 0);
    end
  end

  task automatic cfg_write(logic [3:0] idx, logic [31:0] d);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic send_pixel(logic [11:0] x, logic [11:0] y);
    int g;
    g = pick_gap();
    if (g != 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i.pixel_x = x;
    in_data_i.pixel_y = y;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(in_data_i);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic random_pixels(int n);
    int span, cpx, cpy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 70) begin
        span = (sb.ring_out >> 4) + 8;
        if (span > 2047) span = 2047;
        cpx = sb.cx >> 4;
        cpy = sb.cy >> 4;
        send_pixel(12'(cpx + $urandom_range(0, 2 * span) - span),
                   12'(cpy + $urandom_range(0, 2 * span) - span));
      end else begin
        send_pixel(12'($urandom), 12'($urandom));
      end
    end
  endtask

  task automatic random_config();
    logic [15:0] cxv, cyv, ro;
    cxv = $urandom_range(0, 65535);
    cyv = $urandom_range(0, 65535);
    if ($urandom_range(0, 3) != 0) cxv[3:0] = '0;
    if ($urandom_range(0, 3) != 0) cyv[3:0] = '0;
    ro = $urandom_range(0, 16 * 300);
    cfg_write(REG_CENTER_X, cxv);
    cfg_write(REG_CENTER_Y, cyv);
    cfg_write(REG_RING_OUTER, ro);
    cfg_write(REG_RING_INNER, $urandom_range(0, ro + 100));
    cfg_write(REG_DISK_RADIUS, $urandom_range(0, ro));
    cfg_write(REG_ANGLE_OFFSET, $urandom);
    cfg_write(REG_CODE_WORD, $urandom);
    cfg_write(REG_CONTROL, $urandom);
    cfg_write(4'(REG_CONTROL + $urandom_range(1, 8)), $urandom);
  endtask

  task automatic axis_pixels();
    send_pixel(12'd500, 12'd500);
    send_pixel(12'd530, 12'd500);
    send_pixel(12'd470, 12'd500);
    send_pixel(12'd500, 12'd530);
    send_pixel(12'd500, 12'd470);
    send_pixel(12'd525, 12'd475);
    send_pixel(12'd475, 12'd440);
    send_pixel(12'd560, 12'd535);
    send_pixel(12'd440, 12'd560);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, corner pixels and pixels beside the center
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd898, 12'd898);
    send_pixel(12'd899, 12'd899);
    end_burst();
    drain();

    // ring with chessboard, exact center, axes
    cfg_write(REG_CENTER_X, 16'd8000);
    cfg_write(REG_CENTER_Y, 16'd8000);
    cfg_write(REG_DISK_RADIUS, 16'd480);
    cfg_write(REG_RING_INNER, 16'd480);
    cfg_write(REG_RING_OUTER, 16'd1200);
    cfg_write(REG_ANGLE_OFFSET, 16'd0);
    cfg_write(REG_CODE_WORD, 32'hA5C3_0F96);
    cfg_write(REG_CONTROL, 10'h0A8);
    axis_pixels();
    end_burst();
    drain();

    // straight layout, odd and saturated bit counts
    cfg_write(REG_CONTROL, 10'h07F);
    axis_pixels();
    end_burst();
    drain();
    cfg_write(REG_RING_OUTER, 16'd0);
    cfg_write(REG_CONTROL, 10'h245);
    send_pixel(12'd510, 12'd520);
    send_pixel(12'd490, 12'd480);
    end_burst();
    drain();

    // all-zero and all-one register extremes
    for (int v = 0; v < 2; v++) begin
      for (int r = REG_CENTER_X; r <= REG_CONTROL + 1; r++)
        cfg_write(4'(r), v ? 32'hFFFF_FFFF : 32'h0);
      random_pixels(60);
      end_burst();
      drain();
    end

    for (int ph = 0; ph < 11; ph++) begin
      random_config();
      if (ph == 3) hold_req = 1;
      random_pixels(160);
      end_burst();
      drain();
    end

    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/ctpr_pkg.sv
hdl/ctpr_stage.sv
hdl/coded_target_pixel_renderer.sv
tb/coded_target_pixel_renderer_tb.sv
